>>> hw/rtl/mbhp_pkg.sv
// Package for the MP4 box header parser: payload structs, configuration
// register indexes, header size constants.
// No dependencies.
package mbhp_pkg;

   localparam int SIZE_BITS_DEF = 64;
   localparam int LEN_W         = 64;
   localparam int TYPE_W        = 32;
   localparam int HDR_W         = 5;
   localparam int CNT_W         = 5;
   localparam int CSR_DATA_W    = 64;
   localparam int CSR_IDX_W     = 1;

   // header lengths and byte counts within the header
   localparam logic [HDR_W-1:0] HDR_SHORT  = 5'd8;
   localparam logic [HDR_W-1:0] HDR_LONG   = 5'd16;
   localparam logic [CNT_W-1:0] TYPE_FIRST = 5'd4;
   localparam logic [CNT_W-1:0] TYPE_LAST  = 5'd7;
   localparam logic [CNT_W-1:0] LAST_SHORT = 5'd7;
   localparam logic [CNT_W-1:0] LAST_LONG  = 5'd15;

   // fewest bytes that can still hold a box header
   localparam logic [LEN_W-1:0] MIN_REMAIN = 64'd8;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BUFFER_LENGTH = 1'b0,
      CSR_VALIDATE_FULL = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       start_req;
   } req_type;

   typedef struct packed {
      logic              box_found;
      logic [TYPE_W-1:0] box_type;
      logic [HDR_W-1:0]  header_bytes;
      logic [LEN_W-1:0]  payload_offset;
      logic [LEN_W-1:0]  payload_bytes;
      logic              parse_done;
      logic              bad_data;
   } rsp_type;

   typedef struct packed {
      logic [LEN_W-1:0] buffer_length;
      logic             validate_full;
   } cfg_type;

endpackage

>>> hw/rtl/mbhp_parse.sv
// Per-byte parse state and box header decode for the MP4 box header parser.
// Depends on mbhp_pkg.
module mbhp_parse import mbhp_pkg::*; #(
   parameter int SIZE_BITS = SIZE_BITS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    step,
   input  req_type item,
   input  cfg_type cfg,
   output logic    result_valid,
   output rsp_type result
);

   logic [LEN_W-1:0]     pos_ff, pos_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [SIZE_BITS-1:0] size_ff, size_in;
   logic [TYPE_W-1:0]    type_ff, type_in;
   logic [LEN_W-1:0]     left_ff, left_in;
   logic                 fin_ff, fin_in;

   // state as seen by this byte; a start request clears it
   logic [LEN_W-1:0]     pos_e;
   logic [CNT_W-1:0]     cnt_e;
   logic [SIZE_BITS-1:0] size_e;
   logic [TYPE_W-1:0]    type_e;
   logic [LEN_W-1:0]     left_e;
   logic                 fin_e;

   logic                 now_brw, aft_brw, size_brw, ovr;
   logic [LEN_W-1:0]     now_diff, aft_diff, rem_now, rem_aft, pos_inc, pay, tail;
   logic [SIZE_BITS-1:0] size_base, size_shift, size_n, size_pay;
   logic [TYPE_W-1:0]    type_base, type_ins, type_n;
   logic [HDR_W-1:0]     hdr;
   logic                 is_type, hdr_short, size_zero, finish;
   logic                 nxt_valid;
   rsp_type              nxt;

   always_comb begin
      if (item.start_req) begin
         pos_e  = '0;
         cnt_e  = '0;
         size_e = '0;
         type_e = '0;
         left_e = '0;
         fin_e  = 1'b0;
      end else begin
         pos_e  = pos_ff;
         cnt_e  = cnt_ff;
         size_e = size_ff;
         type_e = type_ff;
         left_e = left_ff;
         fin_e  = fin_ff;
      end
   end

   always_comb begin
      {now_brw, now_diff} = {1'b0, cfg.buffer_length} - {1'b0, pos_e};
      rem_now = now_brw ? '0 : now_diff;
      pos_inc = pos_e + 64'd1;
      // remaining after this byte; the position wraps to zero at the top
      {aft_brw, aft_diff} = {1'b0, cfg.buffer_length} - {1'b0, pos_e} - 65'd1;
      if (&pos_e) begin
         rem_aft = cfg.buffer_length;
      end else begin
         rem_aft = aft_brw ? '0 : aft_diff;
      end

      size_base  = (cnt_e == '0) ? '0 : size_e;
      type_base  = (cnt_e == '0) ? '0 : type_e;
      size_shift = {size_base[SIZE_BITS-9:0], item.data_byte};
      type_ins   = type_base;
      for (int i = 0; i < 4; i++) begin
         if (cnt_e[1:0] == 2'(i)) begin
            type_ins[8*i +: 8] = type_base[8*i +: 8] | item.data_byte;
         end
      end
      is_type = cnt_e inside {[TYPE_FIRST:TYPE_LAST]};
      size_n  = is_type ? size_base : size_shift;
      type_n  = is_type ? type_ins : type_base;

      hdr_short = (cnt_e == LAST_SHORT);
      hdr       = hdr_short ? HDR_SHORT : HDR_LONG;
      size_zero = (size_n == '0);
      {size_brw, size_pay} = {1'b0, size_n} - {1'b0, SIZE_BITS'(hdr)};
      // a size of zero in the short header runs the box to the end of the buffer
      pay = (hdr_short && size_zero) ? rem_aft : LEN_W'(size_pay);
      {ovr, tail} = {1'b0, rem_aft} - {1'b0, pay};
   end

   always_comb begin
      pos_in    = pos_e;
      cnt_in    = cnt_e;
      size_in   = size_e;
      type_in   = type_e;
      left_in   = left_e;
      fin_in    = fin_e;
      nxt_valid = 1'b0;
      nxt       = '0;
      finish    = 1'b0;
      if (!fin_e) begin
         if (left_e != '0) begin
            left_in = left_e - 64'd1;
            pos_in  = pos_inc;
         end else if (cnt_e == '0 && rem_now < MIN_REMAIN) begin
            nxt_valid      = 1'b1;
            nxt.parse_done = 1'b1;
            fin_in         = 1'b1;
         end else begin
            cnt_in  = cnt_e + 5'd1;
            pos_in  = pos_inc;
            size_in = size_n;
            type_in = type_n;
            if (hdr_short) begin
               if (size_n != SIZE_BITS'(1)) begin
                  finish = 1'b1;
               end else if (rem_aft < MIN_REMAIN) begin
                  // 64-bit size announced with no room for it
                  cnt_in         = '0;
                  nxt_valid      = 1'b1;
                  nxt.parse_done = 1'b1;
                  nxt.bad_data   = cfg.validate_full;
                  fin_in         = 1'b1;
               end
            end else if (cnt_e == LAST_LONG) begin
               finish = 1'b1;
            end
            if (finish) begin
               cnt_in    = '0;
               nxt_valid = 1'b1;
               if (size_brw && !(hdr_short && size_zero)) begin
                  nxt.parse_done = 1'b1;
                  nxt.bad_data   = 1'b1;
               end else if (ovr) begin
                  nxt.parse_done = 1'b1;
                  nxt.bad_data   = 1'b1;
                  if (!cfg.validate_full) begin
                     nxt.box_found      = 1'b1;
                     nxt.box_type       = type_n;
                     nxt.header_bytes   = hdr;
                     nxt.payload_offset = pos_inc;
                     nxt.payload_bytes  = pay;
                  end
               end else begin
                  left_in            = pay;
                  nxt.box_found      = 1'b1;
                  nxt.box_type       = type_n;
                  nxt.header_bytes   = hdr;
                  nxt.payload_offset = pos_inc;
                  nxt.payload_bytes  = pay;
                  nxt.parse_done     = (tail < MIN_REMAIN);
               end
               fin_in = nxt.parse_done;
            end
         end
      end
   end

   assign result_valid = nxt_valid;
   assign result       = nxt;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         cnt_ff  <= '0;
         size_ff <= '0;
         type_ff <= '0;
         left_ff <= '0;
         fin_ff  <= 1'b1;
      end else if (step) begin
         pos_ff  <= pos_in;
         cnt_ff  <= cnt_in;
         size_ff <= size_in;
         type_ff <= type_in;
         left_ff <= left_in;
         fin_ff  <= fin_in;
      end
   end

endmodule

>>> hw/rtl/mbhp_rsp_queue.sv
// Two-entry result queue between the parse logic and the rsp channel.
// Depends on mbhp_pkg.
module mbhp_rsp_queue import mbhp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type push_data,
   output logic    full,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   rsp_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       pop;

   assign full      = (cnt_ff == 2'd2);
   assign rsp_valid = (cnt_ff != 2'd0);
   assign rsp_data  = entry_ff[rd_ptr_ff];
   assign pop       = rsp_valid && rsp_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

>>> hw/rtl/mp4_box_header_parser_unit.sv
// MP4 (ISO BMFF) top-level box header parser: one buffer byte per transaction
// on req, one result per box header or end of parse on rsp. The block takes one
// byte per clock while not stalled; a byte's result is registered in the result
// queue and offered on rsp from there. The rate is set by the per-byte update
// of the parse state (position, header byte count, size and type accumulators,
// payload skip count) in mbhp_parse, which each byte must see before the next.
// Results wait in a two-entry queue; the input stalls only while that queue is
// full and the staged byte would produce a result. Write buffer_length and
// validate_full between buffers.
// Depends on mbhp_pkg, mbhp_parse and mbhp_rsp_queue.
module mp4_box_header_parser_unit import mbhp_pkg::*; #(
   parameter int SIZE_BITS = SIZE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [LEN_W-1:0] buf_len_ff;
   logic             validate_ff;
   cfg_type          cfg;

   logic             stg_valid_ff, stg_valid_in;
   req_type          stg_item_ff;
   logic             fire, res_valid, q_full;
   rsp_type          res;

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_len_ff  <= '0;
         validate_ff <= 1'b1;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_BUFFER_LENGTH: buf_len_ff  <= csr_wdata[LEN_W-1:0];
            CSR_VALIDATE_FULL: validate_ff <= csr_wdata[0];
            default:           buf_len_ff  <= buf_len_ff;
         endcase
      end
   end

   assign cfg.buffer_length = buf_len_ff;
   assign cfg.validate_full = validate_ff;

   // staged byte moves on unless its result has no room
   assign fire      = stg_valid_ff && (!res_valid || !q_full);
   assign req_ready = !stg_valid_ff || fire;

   always_comb begin
      if (req_valid && req_ready) begin
         stg_valid_in = 1'b1;
      end else if (fire) begin
         stg_valid_in = 1'b0;
      end else begin
         stg_valid_in = stg_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
      end else begin
         stg_valid_ff <= stg_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         stg_item_ff <= req_data;
      end
   end

   mbhp_parse #(
      .SIZE_BITS (SIZE_BITS)
   ) u_parse (
      .clock        (clock),
      .reset        (reset),
      .step         (fire),
      .item         (stg_item_ff),
      .cfg          (cfg),
      .result_valid (res_valid),
      .result       (res)
   );

   mbhp_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (fire && res_valid),
      .push_data (res),
      .full      (q_full),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   a_bad_ends_parse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.bad_data |-> rsp_data.parse_done)
      else $error("bad_data without parse_done");

   a_no_box_fields_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.box_found |->
         rsp_data.box_type == '0 && rsp_data.header_bytes == '0 &&
         rsp_data.payload_offset == '0 && rsp_data.payload_bytes == '0)
      else $error("box fields set on a result without a box");

   a_hdr_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.box_found |->
         rsp_data.header_bytes == HDR_SHORT || rsp_data.header_bytes == HDR_LONG)
      else $error("header length not 8 or 16");

   a_box_offset: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.box_found && !rsp_data.bad_data |->
         rsp_data.payload_offset <= buf_len_ff)
      else $error("reported payload starts past the buffer");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result pending after reset");

endmodule
